// ===== hdl/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg
// Operation codes and fixed field widths of the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   localparam int ID_BITS   = 5;
   localparam int SEC_BITS  = 16;
   localparam int USEC_BITS = 20;
   localparam int NOW_BITS  = 48;
   localparam int WAIT_BITS = 48;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CHECK  = 2'd3
   } op_type;

   // usec / 1000 as (usec * RECIP_1000) >> RECIP_SHIFT, exact for 20-bit usec
   localparam int            RECIP_SHIFT = 30;
   localparam logic [20:0]   RECIP_1000  = 21'd1073742;
   localparam logic [9:0]    MS_PER_SEC  = 10'd1000;

endpackage

// ===== hdl/sorted_deadline_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_top
// Timer queue kept as a deadline-sorted chain in a one-port-read,
// one-port-write memory; add, delete, query and expiry check by timer id.
// ----------------------------------------------------------------------------
// Usage: send one command word on the req_ channel (operation in req_tuser,
// timer id, delay and current time in req_tdata). Add, delete and query
// return one response word; check returns one word per expired timer in
// deadline order (or one word with tuser low if nothing expired), with
// rsp_tlast on the final word. Every word carries the wait to the new head.
// The chain is walked one entry at a time through the memory's registered
// read port; the time to the first response word grows with each entry
// walked, compared or shifted: add and delete search for the id, then shift
// the chain; check scans the expired prefix, emits it and compacts it.
// Commands are taken one at a time; req_tready is high only when the block
// is idle. A response waits in the output register while rsp_tready is low
// and no further word is loaded until it is taken. Reset empties the queue
// at once (the entry count is cleared, memory contents need no clearing).
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_top #(
   parameter int NUM_TIMERS = 32,
   parameter int TIME_BITS  = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // timer_id[4:0], delay_sec[20:5], delay_usec[40:21], now_ms[88:41]
   input  logic [95:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // expired_id[4:0], is_armed[5], head_valid[6], head_wait_ms[54:7]
   output logic [55:0] rsp_tdata,
   // expired_valid[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);
   import sdtq_pkg::*;

   localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int EW = ID_BITS + TIME_BITS;
   localparam int WB = (TIME_BITS > NOW_BITS) ? TIME_BITS : NOW_BITS;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
   localparam logic [CW-1:0] FULL = CW'(NUM_TIMERS);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CALC    = 5'd1;
   localparam logic [4:0] S_PREP    = 5'd2;
   localparam logic [4:0] S_FIND_RD = 5'd3;
   localparam logic [4:0] S_FIND_EV = 5'd4;
   localparam logic [4:0] S_REM_RD  = 5'd5;
   localparam logic [4:0] S_REM_WR  = 5'd6;
   localparam logic [4:0] S_INS     = 5'd7;
   localparam logic [4:0] S_INS_RD  = 5'd8;
   localparam logic [4:0] S_INS_EV  = 5'd9;
   localparam logic [4:0] S_HEAD_RD = 5'd10;
   localparam logic [4:0] S_HEAD_EV = 5'd11;
   localparam logic [4:0] S_OUT     = 5'd12;
   localparam logic [4:0] S_CHK_RD  = 5'd13;
   localparam logic [4:0] S_CHK_EV  = 5'd14;
   localparam logic [4:0] S_EM_RD   = 5'd15;
   localparam logic [4:0] S_EM_EV   = 5'd16;

   // chain memory, position 0 is the head
   logic [EW-1:0] mem [NUM_TIMERS];
   logic [EW-1:0] rd_q;
   logic          rd_en, wr_en;
   logic [PW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q <= mem[rd_addr];
      end
   end

   logic [ID_BITS-1:0]   rd_id;
   logic [TIME_BITS-1:0] rd_dl;
   assign rd_id = rd_q[EW-1 -: ID_BITS];
   assign rd_dl = rd_q[TIME_BITS-1:0];

   logic [4:0]           state_ff, state_in;
   op_type               op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [SEC_BITS-1:0]  sec_ff, sec_in;
   logic [USEC_BITS-1:0] usec_ff, usec_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [25:0]          sec_ms_ff, sec_ms_in;
   logic [10:0]          usec_ms_ff, usec_ms_in;
   logic [TIME_BITS-1:0] dl_ff, dl_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        sh_ff, sh_in;
   logic [CW-1:0]        k_ff, k_in;
   logic                 arm_ff, arm_in;
   logic                 hv_ff, hv_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in;

   logic                 ov_ff, ov_in;
   logic                 o_ev_ff, o_ev_in;
   logic [ID_BITS-1:0]   o_id_ff, o_id_in;
   logic                 o_arm_ff, o_arm_in;
   logic                 o_hv_ff, o_hv_in;
   logic [WAIT_BITS-1:0] o_wait_ff, o_wait_in;
   logic                 o_last_ff, o_last_in;

   logic                 ld_ok;
   logic [WB-1:0]        now_w;
   logic [40:0]          usec_prod;
   logic [26:0]          delay_ms;
   logic [TIME_BITS:0]   dl_sum;
   logic [CW:0]          src;
   logic [WAIT_BITS-1:0] rd_wait;

   assign ld_ok     = !ov_ff || rsp_tready;
   assign now_w     = WB'(req_tdata[88:41]);
   assign usec_prod = 41'(usec_ff) * 41'(RECIP_1000);
   assign delay_ms  = 27'(sec_ms_ff) + 27'(usec_ms_ff);
   assign dl_sum    = {1'b0, now_ff} + (TIME_BITS+1)'(delay_ms);
   assign src       = {1'b0, idx_ff} + {1'b0, sh_ff};
   assign rd_wait   = (rd_dl <= now_ff) ? WAIT_BITS'(1) : WAIT_BITS'(rd_dl - now_ff);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      sec_in     = sec_ff;
      usec_in    = usec_ff;
      now_in     = now_ff;
      sec_ms_in  = sec_ms_ff;
      usec_ms_in = usec_ms_ff;
      dl_in      = dl_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      sh_in      = sh_ff;
      k_in       = k_ff;
      arm_in     = arm_ff;
      hv_in      = hv_ff;
      wait_in    = wait_ff;
      ov_in      = ov_ff && !rsp_tready;
      o_ev_in    = o_ev_ff;
      o_id_in    = o_id_ff;
      o_arm_in   = o_arm_ff;
      o_hv_in    = o_hv_ff;
      o_wait_in  = o_wait_ff;
      o_last_in  = o_last_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[PW-1:0];
      wr_en      = 1'b0;
      wr_addr    = idx_ff[PW-1:0];
      wr_data    = {id_ff, dl_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = op_type'(req_tuser);
               id_in   = req_tdata[4:0];
               sec_in  = req_tdata[20:5];
               usec_in = req_tdata[40:21];
               now_in  = (now_w > WB'(TMAX)) ? TMAX : TIME_BITS'(now_w);
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            sec_ms_in  = 26'(sec_ff) * 26'(MS_PER_SEC);
            usec_ms_in = usec_prod[RECIP_SHIFT +: 11];
            state_in   = S_PREP;
         end
         S_PREP: begin
            dl_in  = (dl_sum > {1'b0, TMAX}) ? TMAX : dl_sum[TIME_BITS-1:0];
            idx_in = '0;
            arm_in = 1'b0;
            state_in = (op_ff == OP_CHECK) ? S_CHK_RD : S_FIND_RD;
         end
         S_FIND_RD: begin
            if (idx_ff == cnt_ff) begin
               // id not in the chain
               priority if (op_ff == OP_ADD) state_in = S_INS;
               else state_in = S_HEAD_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_FIND_EV;
            end
         end
         S_FIND_EV: begin
            if (rd_id == id_ff) begin
               sh_in = CW'(1);
               priority if (op_ff == OP_QUERY) begin
                  arm_in   = 1'b1;
                  state_in = S_HEAD_RD;
               end else begin
                  state_in = S_REM_RD;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FIND_RD;
            end
         end
         S_REM_RD: begin
            // pull entries down by sh positions
            if (src >= {1'b0, cnt_ff}) begin
               cnt_in = cnt_ff - sh_ff;
               priority if (op_ff == OP_ADD) state_in = S_INS;
               else if (op_ff == OP_CHECK) state_in = S_IDLE;
               else state_in = S_HEAD_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = src[PW-1:0];
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_q;
            idx_in   = idx_ff + CW'(1);
            state_in = S_REM_RD;
         end
         S_INS: begin
            if (cnt_ff == FULL) begin
               arm_in   = 1'b0;
               state_in = S_HEAD_RD;
            end else begin
               arm_in   = 1'b1;
               idx_in   = cnt_ff;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_HEAD_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = PW'(idx_ff - CW'(1));
               state_in = S_INS_EV;
            end
         end
         S_INS_EV: begin
            wr_en = 1'b1;
            if (rd_dl > dl_ff) begin
               wr_data  = rd_q;
               idx_in   = idx_ff - CW'(1);
               state_in = S_INS_RD;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_HEAD_RD;
            end
         end
         S_HEAD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_HEAD_EV;
         end
         S_HEAD_EV: begin
            hv_in    = (cnt_ff != '0);
            wait_in  = (cnt_ff != '0) ? rd_wait : '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (ld_ok) begin
               ov_in     = 1'b1;
               o_ev_in   = 1'b0;
               o_id_in   = '0;
               o_arm_in  = arm_ff;
               o_hv_in   = hv_ff;
               o_wait_in = wait_ff;
               o_last_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_CHK_RD: begin
            if (idx_ff == cnt_ff) begin
               k_in     = idx_ff;
               hv_in    = 1'b0;
               wait_in  = '0;
               idx_in   = '0;
               state_in = (idx_ff == '0) ? S_OUT : S_EM_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CHK_EV;
            end
         end
         S_CHK_EV: begin
            if (rd_dl <= now_ff) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_CHK_RD;
            end else begin
               // first live entry becomes the new head
               k_in     = idx_ff;
               hv_in    = 1'b1;
               wait_in  = rd_wait;
               idx_in   = '0;
               state_in = (idx_ff == '0) ? S_OUT : S_EM_RD;
            end
         end
         S_EM_RD: begin
            rd_en    = 1'b1;
            state_in = S_EM_EV;
         end
         S_EM_EV: begin
            if (ld_ok) begin
               ov_in     = 1'b1;
               o_ev_in   = 1'b1;
               o_id_in   = rd_id;
               o_arm_in  = 1'b0;
               o_hv_in   = hv_ff;
               o_wait_in = wait_ff;
               o_last_in = (idx_ff + CW'(1) == k_ff);
               if (idx_ff + CW'(1) == k_ff) begin
                  idx_in   = '0;
                  sh_in    = k_ff;
                  state_in = S_REM_RD;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_EM_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
      op_ff      <= op_in;
      id_ff      <= id_in;
      sec_ff     <= sec_in;
      usec_ff    <= usec_in;
      now_ff     <= now_in;
      sec_ms_ff  <= sec_ms_in;
      usec_ms_ff <= usec_ms_in;
      dl_ff      <= dl_in;
      idx_ff     <= idx_in;
      sh_ff      <= sh_in;
      k_ff       <= k_in;
      arm_ff     <= arm_in;
      hv_ff      <= hv_in;
      wait_ff    <= wait_in;
      o_ev_ff    <= o_ev_in;
      o_id_ff    <= o_id_in;
      o_arm_ff   <= o_arm_in;
      o_hv_ff    <= o_hv_in;
      o_wait_ff  <= o_wait_in;
      o_last_ff  <= o_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {1'b0, o_wait_ff, o_hv_ff, o_arm_ff, o_id_ff};
   assign rsp_tuser  = o_ev_ff;
   assign rsp_tlast  = o_last_ff;

endmodule
